// ===== rtl/core/pn_pkg.sv =====
// ----------------------------------------------------------------------------
// pn_pkg: shared constants and types of the path normalizer
// Character codes, buffer sizes and the structs passed between the scanner
// and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package pn_pkg;

  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NONE   = 8'h00;

  // write port into the output buffer
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } pn_wr_t;

  // scan result handed to the emitter
  typedef struct packed {
    logic              valid;
    logic [7:0]        start_idx;
    logic [CNT_W-1:0]  len;
    logic signed [7:0] depth;
  } pn_hand_t;

  function automatic logic is_sep(input logic [7:0] b);
    return (b == CH_SLASH) || (b == CH_BSLASH);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/path_normalizer_top.sv =====
// ----------------------------------------------------------------------------
// path_normalizer_top: streaming file path normalizer
// Loads a path byte by byte, reduces it and sends the result forward.
// ----------------------------------------------------------------------------
// Usage:
//   Input: an item is taken at a clock edge with start high and busy low.
//   While loading, one item per cycle is taken. The item with in_last_byte
//   set starts processing; busy stays high until the last result is sent.
//   Bytes past 64 are dropped but a later last byte still starts the work.
//   Output: one item per normalized byte, each shown for one cycle with
//   out_strobe high; the receiver cannot stall, so items are never held.
//   The final item has out_end_of_path set and carries depth and name_pos.
//   An empty result is one item with out_byte_valid low.
// Processing: the scan first fills a three-byte window, then shifts it
//   through the path buffer read port for each byte consumed; compaction
//   of the buffer bytes and emission of the results are both bound by the
//   single read port of the output buffer.
// Reset: synchronous, active low; returns both units to idle. Buffer
//   contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module path_normalizer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_path_byte,
  input  wire logic        in_last_byte,
  output logic             out_strobe,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_end_of_path,
  output logic signed [7:0] out_depth,
  output logic [6:0]       out_name_pos
);
  import pn_pkg::*;

  pn_wr_t   scan_wr;
  pn_hand_t hand;
  logic     scan_busy;
  logic     emit_busy;

  assign busy = scan_busy || emit_busy;

  pn_scanner u_scanner (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_path_byte (in_path_byte),
    .in_last_byte (in_last_byte),
    .emit_busy    (emit_busy),
    .busy         (scan_busy),
    .out_wr       (scan_wr),
    .hand         (hand)
  );

  pn_emitter u_emitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .scan_wr         (scan_wr),
    .hand            (hand),
    .busy            (emit_busy),
    .out_strobe      (out_strobe),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_end_of_path (out_end_of_path),
    .out_depth       (out_depth),
    .out_name_pos    (out_name_pos)
  );

endmodule

`default_nettype wire

// ===== rtl/core/pn_scanner.sv =====
// ----------------------------------------------------------------------------
// pn_scanner: path buffer load and backward scan
// Stores incoming bytes, then walks the buffer from its end with a
// three-byte window and writes the reduced path backwards into the
// output buffer of the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module pn_scanner (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [7:0]      in_path_byte,
  input  wire logic            in_last_byte,
  input  wire logic            emit_busy,
  output logic                 busy,
  output pn_pkg::pn_wr_t       out_wr,
  output pn_pkg::pn_hand_t     hand
);
  import pn_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_CAP   = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic [1:0] M_TOP  = 2'd0;
  localparam logic [1:0] M_SEP  = 2'd1;
  localparam logic [1:0] M_NAME = 2'd2;

  logic [7:0] path_mem [MAX_LEN];
  logic [7:0] rd_data_r;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [1:0]        shift_r, shift_nxt;
  logic [CNT_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic signed [7:0] rp_r, rp_nxt;
  logic signed [7:0] wp_r, wp_nxt;
  logic [CNT_W-1:0]  skip_r, skip_nxt;
  logic signed [7:0] depth_r, depth_nxt;
  logic              trail_r, trail_nxt;
  logic              first_r, first_nxt;
  logic [7:0]        w0_r, w1_r, w2_r;
  logic [7:0]        w0_nxt, w1_nxt, w2_nxt;

  logic              accept;
  logic              room;
  logic [CNT_W-1:0]  cnt_after;
  logic signed [7:0] rp_m3;
  logic              v0, v1, v2;
  logic              put_en;
  logic [7:0]        put_data;

  assign accept    = start && (state_r == S_IDLE) && !emit_busy;
  assign busy      = (state_r != S_IDLE);
  assign room      = (load_cnt_r < CNT_W'(MAX_LEN));
  assign cnt_after = room ? (load_cnt_r + CNT_W'(1)) : load_cnt_r;
  assign rp_m3     = rp_r - 8'sd3;
  assign v0        = (rp_r >= 8'sd0);
  assign v1        = (rp_r >= 8'sd1);
  assign v2        = (rp_r >= 8'sd2);

  // path buffer: written on load, read at the far end of the window
  always_ff @(posedge clk) begin
    if (accept && room) begin
      path_mem[load_cnt_r[ADDR_W-1:0]] <= in_path_byte;
    end
    rd_data_r <= path_mem[rp_m3[ADDR_W-1:0]];
  end

  // scan control
  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    shift_nxt    = shift_r;
    load_cnt_nxt = load_cnt_r;
    n_nxt        = n_r;
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    skip_nxt     = skip_r;
    depth_nxt    = depth_r;
    trail_nxt    = trail_r;
    first_nxt    = first_r;
    w0_nxt       = w0_r;
    w1_nxt       = w1_r;
    w2_nxt       = w2_r;
    put_en       = 1'b0;
    put_data     = CH_NONE;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          load_cnt_nxt = cnt_after;
          if (in_last_byte) begin
            // window starts three past the end so three shifts fill it
            n_nxt        = cnt_after;
            rp_nxt       = $signed({1'b0, cnt_after}) + 8'sd2;
            wp_nxt       = $signed({1'b0, cnt_after}) - 8'sd1;
            load_cnt_nxt = '0;
            skip_nxt     = '0;
            depth_nxt    = '0;
            trail_nxt    = 1'b0;
            first_nxt    = 1'b0;
            mode_nxt     = M_TOP;
            shift_nxt    = 2'd3;
            state_nxt    = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        w0_nxt    = w1_r;
        w1_nxt    = w2_r;
        rp_nxt    = rp_r - 8'sd1;
        state_nxt = S_CAP;
      end
      S_CAP: begin
        w2_nxt    = rd_data_r;
        shift_nxt = shift_r - 2'd1;
        state_nxt = (shift_r == 2'd1) ? S_EVAL : S_SHIFT;
      end
      S_EVAL: begin
        unique case (mode_r)
          M_SEP: begin
            if (v0 && is_sep(w0_r)) begin
              shift_nxt = 2'd1;
              state_nxt = S_SHIFT;
            end else begin
              mode_nxt = M_TOP;
            end
          end
          M_NAME: begin
            if (v0 && !is_sep(w0_r)) begin
              put_en    = 1'b1;
              put_data  = (skip_r == '0) ? w0_r : CH_NONE;
              shift_nxt = 2'd1;
              state_nxt = S_SHIFT;
            end else begin
              if (skip_r != '0) begin
                skip_nxt = skip_r - CNT_W'(1);
              end
              mode_nxt = M_TOP;
            end
          end
          default: begin
            priority if (!v0) begin
              state_nxt = S_FIN;
            end else if (is_sep(w0_r)) begin
              first_nxt = 1'b1;
              if (!first_r) begin
                trail_nxt = 1'b1;
              end
              depth_nxt = depth_r + 8'sd1;
              put_en    = 1'b1;
              put_data  = (skip_r == '0) ? CH_SLASH : CH_NONE;
              mode_nxt  = M_SEP;
              shift_nxt = 2'd1;
              state_nxt = S_SHIFT;
            end else if ((w0_r == CH_DOT) && (!v1 || is_sep(w1_r))) begin
              // "." component
              first_nxt = 1'b1;
              depth_nxt = depth_r - 8'sd1;
              wp_nxt    = wp_r + 8'sd1;
              shift_nxt = 2'd1;
              state_nxt = S_SHIFT;
            end else if ((w0_r == CH_DOT) && v1 && (w1_r == CH_DOT) &&
                         (!v2 || is_sep(w2_r))) begin
              // ".." component: suppress the next name
              first_nxt = 1'b1;
              depth_nxt = depth_r - 8'sd2;
              wp_nxt    = wp_r + 8'sd1;
              skip_nxt  = skip_r + CNT_W'(1);
              shift_nxt = 2'd2;
              state_nxt = S_SHIFT;
            end else begin
              first_nxt = 1'b1;
              put_en    = 1'b1;
              put_data  = (skip_r == '0) ? w0_r : CH_NONE;
              mode_nxt  = M_NAME;
              shift_nxt = 2'd1;
              state_nxt = S_SHIFT;
            end
          end
        endcase
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (put_en) begin
      wp_nxt = wp_r - 8'sd1;
    end
  end

  // writes outside the buffer, below entry 0 or past entry 63, are dropped
  always_comb begin
    out_wr.en   = put_en && !wp_r[7] && !wp_r[6];
    out_wr.addr = wp_r[ADDR_W-1:0];
    out_wr.data = put_data;
  end

  always_comb begin
    hand.valid     = (state_r == S_FIN);
    hand.start_idx = 8'(wp_r + 8'sd1);
    hand.len       = n_r;
    hand.depth     = trail_r ? (depth_r - 8'sd1) : depth_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      mode_r     <= M_TOP;
      shift_r    <= '0;
      load_cnt_r <= '0;
      skip_r     <= '0;
      trail_r    <= 1'b0;
      first_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      shift_r    <= shift_nxt;
      load_cnt_r <= load_cnt_nxt;
      skip_r     <= skip_nxt;
      trail_r    <= trail_nxt;
      first_r    <= first_nxt;
    end
    n_r     <= n_nxt;
    rp_r    <= rp_nxt;
    wp_r    <= wp_nxt;
    depth_r <= depth_nxt;
    w0_r    <= w0_nxt;
    w1_r    <= w1_nxt;
    w2_r    <= w2_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/pn_emitter.sv =====
// ----------------------------------------------------------------------------
// pn_emitter: output buffer, compaction and forward emission
// Holds the backward-built path, squeezes out dropped bytes in place while
// tracking the last component start, then sends the bytes forward.
// ----------------------------------------------------------------------------
`default_nettype none

module pn_emitter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pn_pkg::pn_wr_t    scan_wr,
  input  wire pn_pkg::pn_hand_t  hand,
  output logic                   busy,
  output logic                   out_strobe,
  output logic [7:0]             out_byte,
  output logic                   out_byte_valid,
  output logic                   out_end_of_path,
  output logic signed [7:0]      out_depth,
  output logic [6:0]             out_name_pos
);
  import pn_pkg::*;

  localparam logic [2:0] E_IDLE  = 3'd0;
  localparam logic [2:0] E_CRD   = 3'd1;
  localparam logic [2:0] E_CWR   = 3'd2;
  localparam logic [2:0] E_START = 3'd3;
  localparam logic [2:0] E_NRD   = 3'd4;
  localparam logic [2:0] E_OUT   = 3'd5;
  localparam logic [2:0] E_EMPTY = 3'd6;

  // the slot one past the end is never read back, so it is not stored
  logic [7:0] out_mem [MAX_LEN];
  logic [7:0] rd_r;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  np_r, np_nxt;
  logic [CNT_W-1:0]  lsp_r, lsp_nxt;
  logic signed [7:0] depth_r, depth_nxt;

  pn_wr_t            cwr;
  pn_wr_t            wr;
  logic [ADDR_W-1:0] rd_addr;
  logic              is_last;

  assign busy    = (state_r != E_IDLE);
  assign rd_addr = (state_r == E_CRD) ? i_r[ADDR_W-1:0] : j_r[ADDR_W-1:0];
  assign wr      = scan_wr.en ? scan_wr : cwr;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      out_mem[wr.addr] <= wr.data;
    end
    rd_r <= out_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    len_nxt   = len_r;
    j_nxt     = j_r;
    np_nxt    = np_r;
    lsp_nxt   = lsp_r;
    depth_nxt = depth_r;
    cwr       = '0;

    unique case (state_r)
      E_IDLE: begin
        if (hand.valid) begin
          n_nxt     = hand.len;
          depth_nxt = hand.depth;
          len_nxt   = '0;
          np_nxt    = '0;
          lsp_nxt   = '0;
          i_nxt     = hand.start_idx[CNT_W-1:0];
          state_nxt = (hand.start_idx >= {1'b0, hand.len}) ? E_START : E_CRD;
        end
      end
      E_CRD: begin
        state_nxt = E_CWR;
      end
      E_CWR: begin
        // keep non-empty bytes; note where each component starts
        if (rd_r != CH_NONE) begin
          cwr.en   = 1'b1;
          cwr.addr = len_r[ADDR_W-1:0];
          cwr.data = rd_r;
          len_nxt  = len_r + CNT_W'(1);
          if (is_sep(rd_r)) begin
            lsp_nxt = len_r + CNT_W'(1);
          end else begin
            np_nxt = lsp_r;
          end
        end
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = ((i_r + CNT_W'(1)) == n_r) ? E_START : E_CRD;
      end
      E_START: begin
        j_nxt     = '0;
        state_nxt = (len_r == '0) ? E_EMPTY : E_NRD;
      end
      E_NRD: begin
        state_nxt = E_OUT;
      end
      E_OUT: begin
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = ((j_r + CNT_W'(1)) == len_r) ? E_IDLE : E_NRD;
      end
      E_EMPTY: begin
        state_nxt = E_IDLE;
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  // result ports
  always_comb begin
    is_last         = (state_r == E_EMPTY) ||
                      ((state_r == E_OUT) && ((j_r + CNT_W'(1)) == len_r));
    out_strobe      = (state_r == E_OUT) || (state_r == E_EMPTY);
    out_byte        = (state_r == E_OUT) ? rd_r : CH_NONE;
    out_byte_valid  = (state_r == E_OUT);
    out_end_of_path = is_last;
    out_depth       = is_last ? depth_r : 8'sd0;
    out_name_pos    = is_last ? 7'(np_r) : 7'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    i_r     <= i_nxt;
    n_r     <= n_nxt;
    len_r   <= len_nxt;
    j_r     <= j_nxt;
    np_r    <= np_nxt;
    lsp_r   <= lsp_nxt;
    depth_r <= depth_nxt;
  end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the streaming path normalizer
// Sends paths one byte per item, predicts the normalized bytes, the depth and
// the name position, and compares every output item in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import pn_pkg::*;

  typedef struct {
    logic [7:0]        ch;
    logic              byte_ok;
    logic              eop;
    logic signed [7:0] depth;
    logic [6:0]        name_pos;
  } norm_item_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [7:0]        in_path_byte;
  logic              in_last_byte;
  logic              out_strobe;
  logic [7:0]        out_byte;
  logic              out_byte_valid;
  logic              out_end_of_path;
  logic signed [7:0] out_depth;
  logic [6:0]        out_name_pos;

  path_normalizer_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_path_byte   (in_path_byte),
    .in_last_byte   (in_last_byte),
    .out_strobe     (out_strobe),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_end_of_path(out_end_of_path),
    .out_depth      (out_depth),
    .out_name_pos   (out_name_pos)
  );

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // predictor state
  logic [7:0]  path_buf [MAX_LEN];
  logic [7:0]  norm_buf [MAX_LEN+1];
  int          load_cnt;
  norm_item_t  pending_bytes[$];
  int          mismatch_cnt;
  int          burst_left;

  function automatic bit is_separator(logic [7:0] b);
    return b == CH_SLASH || b == CH_BSLASH;
  endfunction

  function automatic bit sep_at(int p);
    return p >= 0 && p < MAX_LEN && is_separator(path_buf[p]);
  endfunction

  function automatic bit name_at(int p);
    return p >= 0 && p < MAX_LEN && !is_separator(path_buf[p]);
  endfunction

  function automatic bit sep_or_start(int p);
    return p < 0 || is_separator(path_buf[p]);
  endfunction

  // store one byte into the output buffer, moving backwards
  function automatic void norm_put(inout int wp, input logic [7:0] v);
    if (wp >= 0 && wp <= MAX_LEN) norm_buf[wp] = v;
    wp--;
  endfunction

  // backward scan, compaction and emission of the stored path
  function automatic void normalize_path();
    int n, rp, wp, skip, dcnt, len, k, npos;
    bit trail, first;
    norm_item_t it;
    n = load_cnt; rp = n - 1; wp = n - 1;
    skip = 0; dcnt = 0; trail = 0; first = 0; len = 0;
    while (1) begin
      int p;
      p = rp;
      if (sep_at(p)) begin
        if (!first) trail = 1;
        dcnt++;
        norm_put(wp, skip == 0 ? CH_SLASH : CH_NONE);
        while (sep_at(rp)) rp--;
      end else if (p >= 0 && p < MAX_LEN && path_buf[p] == CH_DOT && sep_or_start(p - 1)) begin
        rp = p - 1; dcnt--; wp++;
      end else if (p > 0 && p < MAX_LEN && path_buf[p] == CH_DOT &&
                   path_buf[p-1] == CH_DOT && sep_or_start(p - 2)) begin
        rp = p - 2; dcnt -= 2; wp++; skip++;
      end else if (name_at(p)) begin
        while (name_at(rp)) begin
          norm_put(wp, skip == 0 ? path_buf[rp] : CH_NONE);
          rp--;
        end
        if (skip > 0) skip--;
      end else begin
        break;
      end
      first = 1;
    end
    if (trail) dcnt--;
    wp++;
    for (int i = (wp < 0 ? 0 : wp); i < n; i++)
      if (norm_buf[i] != CH_NONE) begin
        norm_buf[len] = norm_buf[i];
        len++;
      end
    k = len - 1;
    while (k >= 0 && is_separator(norm_buf[k])) k--;
    while (k >= 0 && !is_separator(norm_buf[k])) k--;
    npos = k + 1;
    if (len == 0) begin
      it = '{CH_NONE, 1'b0, 1'b1, dcnt[7:0], npos[6:0]};
      pending_bytes.push_back(it);
    end else begin
      for (int i = 0; i < len; i++) begin
        it.ch = norm_buf[i];
        it.byte_ok = 1'b1;
        it.eop = (i == len - 1);
        it.depth = it.eop ? dcnt[7:0] : 8'sd0;
        it.name_pos = it.eop ? npos[6:0] : 7'd0;
        pending_bytes.push_back(it);
      end
    end
    load_cnt = 0;
  endfunction

  function automatic void accept_byte(logic [7:0] b, logic last);
    if (load_cnt < MAX_LEN) begin
      path_buf[load_cnt] = b;
      load_cnt++;
    end
    if (last) normalize_path();
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // output checker
  always @(posedge clk) begin
    norm_item_t w;
    if (rst_n && out_strobe) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected output item, byte", out_byte, -1);
      end else begin
        w = pending_bytes.pop_front();
        if (out_byte !== w.ch) report_mismatch("out_byte", out_byte, w.ch);
        if (out_byte_valid !== w.byte_ok)
          report_mismatch("out_byte_valid", out_byte_valid, w.byte_ok);
        if (out_end_of_path !== w.eop)
          report_mismatch("out_end_of_path", out_end_of_path, w.eop);
        if (out_depth !== w.depth) report_mismatch("out_depth", out_depth, w.depth);
        if (out_name_pos !== w.name_pos)
          report_mismatch("out_name_pos", out_name_pos, w.name_pos);
      end
    end
  end

  // one item; sender gaps come between bursts
  task automatic send_item(logic [7:0] b, logic last);
    start <= 1'b1;
    in_path_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (busy);
    accept_byte(b, last);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_path(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  task automatic send_bytes(logic [7:0] q[$]);
    for (int i = 0; i < q.size(); i++) send_item(q[i], i == q.size() - 1);
  endtask

  // full-length path first: every output buffer entry gets written
  task automatic test_full_length();
    logic [7:0] q[$];
    for (int i = 0; i < MAX_LEN; i++) q.push_back(8'(8'h61 + (i % 26)));
    send_bytes(q);
  endtask

  task automatic test_directed();
    logic [7:0] q[$];
    send_path("/a//b/");
    send_path("\\\\");
    send_path("./a");
    send_path("../x/..");
    send_path("a/./b");
    send_path(".");
    send_path("..");
    send_path("a/b/../c");
    send_path("/");
    q = '{8'h00, 8'hFF, 8'h2F, 8'h7F, 8'h80};
    send_bytes(q);
  endtask

  // longer than the buffer: tail is dropped
  task automatic test_overflow();
    logic [7:0] q[$];
    for (int i = 0; i < MAX_LEN + 6; i++)
      q.push_back((i % 5 == 4) ? CH_SLASH : 8'(8'h41 + i % 20));
    send_bytes(q);
  endtask

  // random paths built from components, with some noise paths
  task automatic test_random(int n_items);
    logic [7:0] q[$];
    int sent, lim;
    sent = 0;
    while (sent < n_items) begin
      q.delete();
      lim = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 72) : $urandom_range(1, 14);
      if ($urandom_range(0, 7) == 0) begin
        repeat (lim) q.push_back(8'($urandom_range(0, 255)));
      end else begin
        while (q.size() < lim) begin
          case ($urandom_range(0, 5))
            0: q.push_back(CH_DOT);
            1: begin q.push_back(CH_DOT); q.push_back(CH_DOT); end
            2, 3: repeat ($urandom_range(1, 4))
                    q.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                                          : 8'(8'h61 + $urandom_range(0, 25)));
            default: ;
          endcase
          repeat ($urandom_range(1, 2))
            q.push_back($urandom_range(0, 1) ? CH_SLASH : CH_BSLASH);
        end
        if ($urandom_range(0, 2) == 0) void'(q.pop_back());
      end
      send_bytes(q);
      sent += q.size();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_path_byte = '0;
    in_last_byte = 1'b0;
    load_cnt = 0;
    mismatch_cnt = 0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_full_length();
    test_directed();
    test_overflow();
    test_random(260);
    start <= 1'b0;
    wait (pending_bytes.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// ===== path_normalizer_top.f =====
rtl/core/pn_pkg.sv
rtl/core/pn_scanner.sv
rtl/core/pn_emitter.sv
rtl/core/path_normalizer_top.sv
sim/tb_top.sv
